[hdl/multiplicative_digital_root_classifier_unit_assert.svh]
// Assertion macros shared by the classifier RTL.
`ifndef MULTIPLICATIVE_DIGITAL_ROOT_CLASSIFIER_UNIT_ASSERT_SVH
`define MULTIPLICATIVE_DIGITAL_ROOT_CLASSIFIER_UNIT_ASSERT_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define MDR_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every clock edge outside reset.
`define MDR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/mdr_pkg.sv]
package mdr_pkg;

  localparam int unsigned NUM_W    = 64;
  localparam int unsigned BASE_W   = 11;
  localparam int unsigned ROOT_W   = 10;
  localparam int unsigned MODE_W   = 2;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned ADDR_W   = 3;
  localparam int unsigned DATA_W   = 32;

  // Bits of the dividend consumed by the divider in one cycle.
  localparam int unsigned DIV_STEPS = 8;
  localparam int unsigned CNT_W     = $clog2(NUM_W / DIV_STEPS);

  localparam logic [BASE_W-1:0] MIN_BASE   = BASE_W'(2);
  localparam logic [BASE_W-1:0] MAX_BASE   = BASE_W'(1024);
  localparam logic [BASE_W-1:0] RESET_BASE = BASE_W'(10);

  localparam logic [MODE_W-1:0] MODE_MAGNITUDE = 2'd0;
  localparam logic [MODE_W-1:0] MODE_DROP      = 2'd1;
  localparam logic [MODE_W-1:0] MODE_ERROR     = 2'd2;

  localparam logic [STATUS_W-1:0] ST_CLASSIFIED = 2'd0;
  localparam logic [STATUS_W-1:0] ST_DROPPED    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_ERROR      = 2'd2;

  localparam logic REG_DIGIT_BASE    = 1'b0;
  localparam logic REG_NEGATIVE_MODE = 1'b1;

endpackage

[hdl/multiplicative_digital_root_classifier_unit.sv]
// Flow: an item that is dropped, flagged or below the base goes from S_IDLE straight to S_FINISH.
// Otherwise each digit takes S_DIV steps of the shared 8-bit-per-cycle remainder divider and then
// an S_MUL step of the shared multiplier, each pass ends in S_CHK, and S_FINISH registers the result.
// Throughput: one item at a time; a new transfer is taken once the result is registered.
// Reset: asynchronous, active low; digit_base returns to 10, negative_mode to 0, no result pending.
`include "multiplicative_digital_root_classifier_unit_assert.svh"

module multiplicative_digital_root_classifier_unit import mdr_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ADDR_W-1:0]   paddr,
  input  logic [DATA_W-1:0]   pwdata,
  output logic [DATA_W-1:0]   prdata,
  output logic                pready,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic signed [NUM_W-1:0] number_in_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [ROOT_W-1:0]   root_bin_o,
  output logic [NUM_W-1:0]    value_out_o,
  output logic [STATUS_W-1:0] status_o
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DIV    = 3'd1;
  localparam logic [2:0] S_MUL    = 3'd2;
  localparam logic [2:0] S_CHK    = 3'd3;
  localparam logic [2:0] S_FINISH = 3'd4;

  logic [BASE_W-1:0]   digit_base_q, digit_base_d;
  logic [MODE_W-1:0]   negative_mode_q, negative_mode_d;
  logic [BASE_W-1:0]   base_eff;

  logic [2:0]          state_q, state_d;
  logic [NUM_W-1:0]    quo_q, quo_d;
  logic [ROOT_W-1:0]   rem_q, rem_d;
  logic [NUM_W-1:0]    prod_q, prod_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic [NUM_W-1:0]    value_q, value_d;
  logic [ROOT_W-1:0]   root_q, root_d;
  logic [STATUS_W-1:0] status_q, status_d;

  logic                out_valid_q, out_valid_d;
  logic [ROOT_W-1:0]   out_root_q, out_root_d;
  logic [NUM_W-1:0]    out_value_q, out_value_d;
  logic [STATUS_W-1:0] out_status_q, out_status_d;

  logic                cfg_write;
  logic                in_xfer;
  logic                negative;
  logic [NUM_W-1:0]    magnitude;
  logic [NUM_W-1:0]    div_quo;
  logic [ROOT_W-1:0]   div_rem;
  logic [NUM_W+ROOT_W-1:0] mul_full;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_comb begin
    digit_base_d    = digit_base_q;
    negative_mode_d = negative_mode_q;
    if (cfg_write) begin
      case (paddr[2])
        REG_DIGIT_BASE:    digit_base_d    = pwdata[BASE_W-1:0];
        REG_NEGATIVE_MODE: negative_mode_d = pwdata[MODE_W-1:0];
        default:           digit_base_d    = digit_base_q;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_DIGIT_BASE:    prdata = DATA_W'(digit_base_q);
      REG_NEGATIVE_MODE: prdata = DATA_W'(negative_mode_q);
      default:           prdata = '0;
    endcase
  end

  always_comb begin
    if (digit_base_q < MIN_BASE) begin
      base_eff = MIN_BASE;
    end else if (digit_base_q > MAX_BASE) begin
      base_eff = MAX_BASE;
    end else begin
      base_eff = digit_base_q;
    end
  end

  assign in_ready_o = (state_q == S_IDLE);
  assign in_xfer    = in_valid_i && in_ready_o;
  assign negative   = number_in_i[NUM_W-1];
  assign magnitude  = negative ? (~number_in_i + NUM_W'(1)) : number_in_i;

  // Restoring division of the running quotient by the base, several bits a cycle.
  always_comb begin
    logic [BASE_W-1:0] trial;
    logic [ROOT_W-1:0] r;
    logic [NUM_W-1:0]  q;
    r = rem_q;
    q = quo_q;
    for (int i = 0; i < DIV_STEPS; i++) begin
      trial = {r, q[NUM_W-1]};
      q     = {q[NUM_W-2:0], 1'b0};
      if (trial >= base_eff) begin
        r    = ROOT_W'(trial - base_eff);
        q[0] = 1'b1;
      end else begin
        r = trial[ROOT_W-1:0];
      end
    end
    div_quo = q;
    div_rem = r;
  end

  assign mul_full = prod_q * rem_q;

  always_comb begin
    state_d      = state_q;
    quo_d        = quo_q;
    rem_d        = rem_q;
    prod_d       = prod_q;
    cnt_d        = cnt_q;
    value_d      = value_q;
    root_d       = root_q;
    status_d     = status_q;
    out_valid_d  = out_valid_q;
    out_root_d   = out_root_q;
    out_value_d  = out_value_q;
    out_status_d = out_status_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          rem_d  = '0;
          cnt_d  = '0;
          prod_d = NUM_W'(1);
          quo_d  = magnitude;
          if (negative && negative_mode_q == MODE_DROP) begin
            status_d = ST_DROPPED;
            root_d   = '0;
            value_d  = '0;
            state_d  = S_FINISH;
          end else if (negative && negative_mode_q != MODE_MAGNITUDE) begin
            status_d = ST_ERROR;
            root_d   = '0;
            value_d  = '0;
            state_d  = S_FINISH;
          end else begin
            status_d = ST_CLASSIFIED;
            value_d  = magnitude;
            root_d   = magnitude[ROOT_W-1:0];
            if (magnitude < NUM_W'(base_eff)) begin
              state_d = S_FINISH;
            end else begin
              state_d = S_DIV;
            end
          end
        end
      end
      S_DIV: begin
        quo_d = div_quo;
        rem_d = div_rem;
        cnt_d = cnt_q + CNT_W'(1);
        if (cnt_q == '1) begin
          state_d = S_MUL;
        end
      end
      S_MUL: begin
        prod_d = mul_full[NUM_W-1:0];
        rem_d  = '0;
        cnt_d  = '0;
        if (quo_q != '0) begin
          state_d = S_DIV;
        end else begin
          state_d = S_CHK;
        end
      end
      S_CHK: begin
        if (prod_q < NUM_W'(base_eff)) begin
          root_d  = prod_q[ROOT_W-1:0];
          state_d = S_FINISH;
        end else begin
          quo_d   = prod_q;
          prod_d  = NUM_W'(1);
          rem_d   = '0;
          cnt_d   = '0;
          state_d = S_DIV;
        end
      end
      S_FINISH: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d  = 1'b1;
          out_root_d   = root_q;
          out_value_d  = value_q;
          out_status_d = status_q;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      digit_base_q    <= RESET_BASE;
      negative_mode_q <= MODE_MAGNITUDE;
      state_q         <= S_IDLE;
      cnt_q           <= '0;
      out_valid_q     <= 1'b0;
    end else begin
      digit_base_q    <= digit_base_d;
      negative_mode_q <= negative_mode_d;
      state_q         <= state_d;
      cnt_q           <= cnt_d;
      out_valid_q     <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q        <= quo_d;
    rem_q        <= rem_d;
    prod_q       <= prod_d;
    value_q      <= value_d;
    root_q       <= root_d;
    status_q     <= status_d;
    out_root_q   <= out_root_d;
    out_value_q  <= out_value_d;
    out_status_q <= out_status_d;
  end

  assign out_valid_o = out_valid_q;
  assign root_bin_o  = out_root_q;
  assign value_out_o = out_value_q;
  assign status_o    = out_status_q;

  `MDR_ASSERT(a_rem_below_base, state_q == S_DIV, BASE_W'(rem_q) < base_eff,
    "Divider remainder reached the base.")

  `MDR_ASSERT(a_root_below_base, out_valid_o && status_o == ST_CLASSIFIED,
    BASE_W'(root_bin_o) < base_eff && NUM_W'(root_bin_o) <= value_out_o,
    "Classified root is not a single digit of its magnitude.")

  `MDR_ASSERT(a_reject_zeroed, out_valid_o && status_o != ST_CLASSIFIED,
    root_bin_o == '0 && value_out_o == '0,
    "Dropped or flagged result carries a nonzero payload.")

  `MDR_ASSERT_NEXT(a_pass_start, in_xfer,
    state_q != S_DIV || (prod_q == NUM_W'(1) && rem_q == '0 && cnt_q == '0),
    "First pass did not start from a clean product and remainder.")

endmodule

[bench/multiplicative_digital_root_classifier_unit_tb.sv]
`timescale 1ns / 100ps

module multiplicative_digital_root_classifier_unit_tb;
  import mdr_pkg::*;

  localparam logic [ADDR_W-1:0] ADDR_DIGIT_BASE    = {REG_DIGIT_BASE, 2'b00};
  localparam logic [ADDR_W-1:0] ADDR_NEGATIVE_MODE = {REG_NEGATIVE_MODE, 2'b00};
  localparam logic [MODE_W-1:0] MODE_SPARE         = 2'd3;
  localparam int unsigned       STALL_LIMIT        = 20000;
  localparam int unsigned       SETTLE_CYCLES      = 250;
  localparam int unsigned       NUM_DIRECTED       = 26;
  localparam int unsigned       NUM_PHASES         = 10;
  localparam logic [NUM_W-1:0]  MAX_POS            = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [NUM_W-1:0]  MOST_NEG           = 64'h8000_0000_0000_0000;

  typedef struct packed {
    logic [ROOT_W-1:0]   root;
    logic [NUM_W-1:0]    value;
    logic [STATUS_W-1:0] status;
  } bin_entry_t;

  typedef struct packed {
    logic [BASE_W-1:0]   base;
    logic [MODE_W-1:0]   mode;
    logic [NUM_W-1:0]    number;
    logic                typed;
    logic [ROOT_W-1:0]   root;
    logic [NUM_W-1:0]    value;
    logic [STATUS_W-1:0] status;
  } directed_row_t;

  typedef struct packed {
    logic [BASE_W-1:0] base;
    logic [MODE_W-1:0] mode;
    logic [15:0]       count;
  } cfg_phase_t;

  logic                    clk_i;
  logic                    rst_ni;
  logic                    psel;
  logic                    penable;
  logic                    pwrite;
  logic [ADDR_W-1:0]       paddr;
  logic [DATA_W-1:0]       pwdata;
  logic [DATA_W-1:0]       prdata;
  logic                    pready;
  logic                    in_valid_i;
  logic                    in_ready_o;
  logic signed [NUM_W-1:0] number_in_i;
  logic                    out_valid_o;
  logic                    out_ready_i;
  logic [ROOT_W-1:0]       root_bin_o;
  logic [NUM_W-1:0]        value_out_o;
  logic [STATUS_W-1:0]     status_o;

  logic              typed_pending;
  bin_entry_t        typed_entry;
  logic              calm;
  logic [BASE_W-1:0] cfg_base;
  logic [MODE_W-1:0] cfg_mode;

  bin_entry_t    expected_bins[$];
  int unsigned   sent_count;
  int unsigned   done_count;
  int unsigned   fault_count;
  int unsigned   quiet_cycles;
  int unsigned   item_idx;
  directed_row_t directed_rows [NUM_DIRECTED];
  cfg_phase_t    cfg_phases [NUM_PHASES];

  multiplicative_digital_root_classifier_unit DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .number_in_i (number_in_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .root_bin_o  (root_bin_o),
    .value_out_o (value_out_o),
    .status_o    (status_o)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  function automatic logic [NUM_W-1:0] digit_base_of(input logic [BASE_W-1:0] base_reg);
    if (base_reg < MIN_BASE) begin
      return 64'(MIN_BASE);
    end
    if (base_reg > MAX_BASE) begin
      return 64'(MAX_BASE);
    end
    return 64'(base_reg);
  endfunction

  function automatic bin_entry_t classify(input logic [NUM_W-1:0] raw,
                                          input logic [BASE_W-1:0] base_reg,
                                          input logic [MODE_W-1:0] mode_reg);
    bin_entry_t       entry;
    logic [NUM_W-1:0] b;
    logic [NUM_W-1:0] n;
    logic [NUM_W-1:0] prod;
    logic [NUM_W-1:0] rest;
    entry = '0;
    b = digit_base_of(base_reg);
    if (raw[NUM_W-1] && mode_reg == MODE_DROP) begin
      entry.status = ST_DROPPED;
    end else if (raw[NUM_W-1] && mode_reg != MODE_MAGNITUDE) begin
      entry.status = ST_ERROR;
    end else begin
      n = raw[NUM_W-1] ? -raw : raw;
      entry.value = n;
      entry.status = ST_CLASSIFIED;
      while (n >= b) begin
        prod = 64'd1;
        rest = n;
        while (rest != 64'd0) begin
          prod = prod * (rest % b);
          rest = rest / b;
        end
        n = prod;
      end
      entry.root = n[ROOT_W-1:0];
    end
    return entry;
  endfunction

  function automatic logic [NUM_W-1:0] pick_number(input logic [NUM_W-1:0] b);
    logic [NUM_W-1:0] n;
    int unsigned      sel;
    int unsigned      k;
    sel = $urandom_range(99);
    n = '0;
    if (sel < 50) begin
      k = $urandom_range(64, 1);
      while (k > 0 && n < (MAX_POS / b)) begin
        n = n * b + 64'($urandom_range(32'(b) - 1, 1));
        k--;
      end
    end else if (sel < 62) begin
      n = 64'($urandom_range(32'(b) - 1, 0));
    end else if (sel < 92) begin
      n = {$urandom(), $urandom()};
    end else begin
      case ($urandom_range(4))
        0: n = 64'd0;
        1: n = MAX_POS;
        2: n = MOST_NEG;
        3: n = '1;
        default: n = 64'd1;
      endcase
    end
    if (sel < 62 && $urandom_range(99) < 30) begin
      n = -n;
    end
    return n;
  endfunction

  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (done_count < sent_count) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_config(input logic [BASE_W-1:0] base, input logic [MODE_W-1:0] mode);
    drain_results();
    write_reg(ADDR_DIGIT_BASE, ($urandom() & ~32'h7FF) | 32'(base));
    write_reg(ADDR_NEGATIVE_MODE, ($urandom() & ~32'h3) | 32'(mode));
    cfg_base = base;
    cfg_mode = mode;
  endtask

  task automatic send_number(input logic [NUM_W-1:0] n, input logic typed,
                             input bin_entry_t entry);
    if (!calm && $urandom_range(99) < 14) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(250, 1)) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    number_in_i   <= n;
    typed_pending <= typed;
    typed_entry   <= entry;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sent_count++;
  endtask

  always @(posedge clk_i) begin
    out_ready_i <= calm ? 1'b1 : ($urandom_range(99) >= 14);
  end

  always @(posedge clk_i) begin
    bin_entry_t want;
    bin_entry_t got;
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || psel) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (in_valid_i && in_ready_o) begin
        expected_bins.insert(expected_bins.size(),
                             typed_pending ? typed_entry
                                           : classify(number_in_i, cfg_base, cfg_mode));
      end
      if (out_valid_o && out_ready_i) begin
        done_count++;
        got = '{root_bin_o, value_out_o, status_o};
        if (expected_bins.size() == 0) begin
          if (fault_count < 10) begin
            $display("Unexpected result transfer: root %0d value %0h status %0d",
                     got.root, got.value, got.status);
          end
          fault_count++;
        end else begin
          want = expected_bins.pop_front();
          if (got.root !== want.root || got.value !== want.value ||
              got.status !== want.status) begin
            if (fault_count < 10) begin
              $display("Mismatch: root %0d/%0d value %0h/%0h status %0d/%0d (exp/act)",
                       want.root, got.root, want.value, got.value, want.status, got.status);
            end
            fault_count++;
          end
        end
      end
    end
  end

  initial begin
    while (quiet_cycles < STALL_LIMIT) @(posedge clk_i);
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    rst_ni        = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    in_valid_i    = 1'b0;
    number_in_i   = '0;
    out_ready_i   = 1'b0;
    typed_pending = 1'b0;
    typed_entry   = '0;
    calm          = 1'b0;
    cfg_base      = RESET_BASE;
    cfg_mode      = MODE_MAGNITUDE;
    sent_count    = 0;
    done_count    = 0;
    fault_count   = 0;
    quiet_cycles  = 0;
    item_idx      = 0;

    directed_rows = '{
      '{11'd10, MODE_MAGNITUDE, 64'd0, 1'b1, 10'd0, 64'd0, ST_CLASSIFIED},
      '{11'd10, MODE_MAGNITUDE, 64'd7, 1'b1, 10'd7, 64'd7, ST_CLASSIFIED},
      '{11'd10, MODE_MAGNITUDE, 64'd9, 1'b1, 10'd9, 64'd9, ST_CLASSIFIED},
      '{11'd10, MODE_MAGNITUDE, 64'd10, 1'b0, 10'd0, 64'd0, ST_CLASSIFIED},
      '{11'd10, MODE_MAGNITUDE, 64'd39, 1'b0, 10'd0, 64'd0, ST_CLASSIFIED},
      '{11'd10, MODE_MAGNITUDE, 64'd277777788888899, 1'b0, 10'd0, 64'd0, ST_CLASSIFIED},
      '{11'd10, MODE_MAGNITUDE, MAX_POS, 1'b0, 10'd0, 64'd0, ST_CLASSIFIED},
      '{11'd10, MODE_MAGNITUDE, MOST_NEG, 1'b0, 10'd0, 64'd0, ST_CLASSIFIED},
      '{11'd10, MODE_MAGNITUDE, -64'd1, 1'b1, 10'd1, 64'd1, ST_CLASSIFIED},
      '{11'd10, MODE_MAGNITUDE, -64'd7, 1'b1, 10'd7, 64'd7, ST_CLASSIFIED},
      '{11'd10, MODE_DROP, -64'd5, 1'b1, 10'd0, 64'd0, ST_DROPPED},
      '{11'd10, MODE_DROP, MOST_NEG, 1'b1, 10'd0, 64'd0, ST_DROPPED},
      '{11'd10, MODE_DROP, 64'd25, 1'b0, 10'd0, 64'd0, ST_CLASSIFIED},
      '{11'd10, MODE_ERROR, -64'd1, 1'b1, 10'd0, 64'd0, ST_ERROR},
      '{11'd10, MODE_ERROR, MAX_POS, 1'b0, 10'd0, 64'd0, ST_CLASSIFIED},
      '{11'd10, MODE_SPARE, -64'd3, 1'b1, 10'd0, 64'd0, ST_ERROR},
      '{11'd10, MODE_SPARE, 64'd0, 1'b1, 10'd0, 64'd0, ST_CLASSIFIED},
      '{11'd0, MODE_MAGNITUDE, 64'd1, 1'b1, 10'd1, 64'd1, ST_CLASSIFIED},
      '{11'd0, MODE_MAGNITUDE, 64'd6, 1'b0, 10'd0, 64'd0, ST_CLASSIFIED},
      '{11'd0, MODE_MAGNITUDE, -64'd1, 1'b1, 10'd1, 64'd1, ST_CLASSIFIED},
      '{11'd2047, MODE_MAGNITUDE, 64'd1023, 1'b1, 10'd1023, 64'd1023, ST_CLASSIFIED},
      '{11'd2047, MODE_MAGNITUDE, 64'd1024, 1'b0, 10'd0, 64'd0, ST_CLASSIFIED},
      '{11'd2047, MODE_MAGNITUDE, MAX_POS, 1'b0, 10'd0, 64'd0, ST_CLASSIFIED},
      '{11'd1024, MODE_ERROR, -64'd1024, 1'b1, 10'd0, 64'd0, ST_ERROR},
      '{11'd1, MODE_DROP, MOST_NEG, 1'b1, 10'd0, 64'd0, ST_DROPPED},
      '{11'd1, MODE_DROP, 64'd5, 1'b0, 10'd0, 64'd0, ST_CLASSIFIED}
    };

    cfg_phases = '{
      '{11'd10, MODE_MAGNITUDE, 16'd300},
      '{11'd2, MODE_DROP, 16'd60},
      '{11'd1024, MODE_ERROR, 16'd120},
      '{11'd3, MODE_SPARE, 16'd60},
      '{11'd0, MODE_MAGNITUDE, 16'd40},
      '{11'd1, MODE_DROP, 16'd30},
      '{11'd2047, MODE_MAGNITUDE, 16'd80},
      '{11'd16, MODE_ERROR, 16'd100},
      '{11'd7, MODE_MAGNITUDE, 16'd100},
      '{11'd10, MODE_DROP, 16'd110}
    };

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int r = 0; r < NUM_DIRECTED; r++) begin
      if (directed_rows[r].base != cfg_base || directed_rows[r].mode != cfg_mode) begin
        set_config(directed_rows[r].base, directed_rows[r].mode);
      end
      send_number(directed_rows[r].number, directed_rows[r].typed,
                  '{directed_rows[r].root, directed_rows[r].value, directed_rows[r].status});
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      set_config(cfg_phases[p].base, cfg_phases[p].mode);
      for (int i = 0; i < int'(cfg_phases[p].count); i++) begin
        calm <= (item_idx >= 200 && item_idx < 350);
        if (item_idx == 500) begin
          drain_results();
        end
        send_number(pick_number(digit_base_of(cfg_base)), 1'b0, '0);
        item_idx++;
      end
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    fault_count += expected_bins.size();
    if (fault_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+hdl
hdl/mdr_pkg.sv
hdl/multiplicative_digital_root_classifier_unit.sv
bench/multiplicative_digital_root_classifier_unit_tb.sv
